// ===== rtl/dia_pkg.sv =====
// types, codes and constants shared by the descriptor index allocator
package dia_pkg;

   localparam int POOL_COUNT  = 4;
   localparam int POOL_W      = 2;
   localparam int VIEW_W      = 3;
   localparam int INDEX_W     = 10;
   localparam int INDEX_LIMIT = 1024;
   localparam int CAP_W       = 11;
   localparam int STRIDE_W    = 8;
   localparam int OFFSET_W    = 18;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 48;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_FULL         = 2'd1,
      STATUS_NOT_ALLOC    = 2'd2,
      STATUS_OUT_OF_RANGE = 2'd3
   } status_type;

   localparam logic [VIEW_W-1:0] VIEW_RTV     = 3'd0;
   localparam logic [VIEW_W-1:0] VIEW_DSV     = 3'd1;
   localparam logic [VIEW_W-1:0] VIEW_SAMPLER = 3'd5;

   localparam logic [POOL_W-1:0] POOL_RTV      = 2'd0;
   localparam logic [POOL_W-1:0] POOL_DSV      = 2'd1;
   localparam logic [POOL_W-1:0] POOL_RESOURCE = 2'd2;
   localparam logic [POOL_W-1:0] POOL_SAMPLER  = 2'd3;

   // register indexes: capacities first, then strides
   localparam logic [CSR_ADDR_W-1:0] CSR_RTV_CAPACITY = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RTV_STRIDE   = 3'd4;

   localparam logic [CAP_W-1:0] CAP_RESET [POOL_COUNT] =
      '{11'd64, 11'd64, 11'd1024, 11'd64};
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd32;

   typedef struct packed {
      op_type              op;
      logic [POOL_W-1:0]   pool;
      logic [INDEX_W-1:0]  index;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // first member lands in the top bits
   typedef struct packed {
      logic [CAP_W-1:0]    allocated_count;
      status_type          status;
      logic                shader_visible;
      logic [OFFSET_W-1:0] byte_offset;
      logic [INDEX_W-1:0]  slot_index;
      logic [POOL_W-1:0]   pool_id;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   function automatic logic [POOL_W-1:0] pool_of_view(input logic [VIEW_W-1:0] view);
      logic [POOL_W-1:0] pool;
      case (view)
         VIEW_RTV:     pool = POOL_RTV;
         VIEW_DSV:     pool = POOL_DSV;
         VIEW_SAMPLER: pool = POOL_SAMPLER;
         default:      pool = POOL_RESOURCE;
      endcase
      return pool;
   endfunction

endpackage

// ===== rtl/dia_front.sv =====
// request front end: decodes the pool of each word and queues it for the engine
module dia_front
   import dia_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output queue_head_type        head,
   input  logic                  pop
);

   item_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]      count_ff, count_in;
   item_type                 item_in;
   logic                     push;

   always_comb begin
      item_in.op    = op_type'(req_tdata[0]);
      item_in.pool  = pool_of_view(req_tdata[3:1]);
      item_in.index = req_tdata[13:4];
   end

   assign req_tready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== rtl/dia_back.sv =====
// allocation engine: free stacks, allocated bitmap, pool counters and result register
module dia_back
   import dia_pkg::*;
#(
   parameter int POOL_DEPTH = 1024
)
(
   input  logic                clock,
   input  logic                reset,
   input  queue_head_type      head,
   output logic                pop,
   input  logic [CAP_W-1:0]    capacity [POOL_COUNT],
   input  logic [STRIDE_W-1:0] stride   [POOL_COUNT],
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output result_type          rsp_result
);

   localparam int MAP_DEPTH = (POOL_DEPTH < INDEX_LIMIT) ? POOL_DEPTH : INDEX_LIMIT;
   localparam int AW        = $clog2(MAP_DEPTH);
   localparam int CW        = $clog2(MAP_DEPTH + 1);
   localparam int MEM_AW    = POOL_W + AW;
   localparam int MEM_DEPTH = POOL_COUNT << AW;

   typedef enum logic [1:0] {
      ST_READ = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

   back_state_type        state_ff, state_in;
   item_type              item_ff;
   logic [CW-1:0]         depth_ff [POOL_COUNT];
   logic [CW-1:0]         hwm_ff   [POOL_COUNT];
   logic [CW-1:0]         live_ff  [POOL_COUNT];
   logic [INDEX_W-1:0]    stack_mem [MEM_DEPTH];
   logic                  map_mem   [MEM_DEPTH];
   logic [INDEX_W-1:0]    stack_rd_ff;
   logic                  map_rd_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff, rsp_in;

   logic [CW-1:0]         head_depth, head_depth_dec;
   logic [MEM_AW-1:0]     stack_rd_addr, map_rd_addr;
   logic                  exec_go;
   logic [CW-1:0]         cur_depth, cur_hwm, cur_live;
   logic [CAP_W-1:0]      cur_cap;
   logic [CAP_W-1:0]      map_limit;
   logic                  bump_ok, index_ok, map_hit;
   logic                  ok;
   logic [INDEX_W-1:0]    slot;
   status_type            status;
   logic [CW-1:0]         depth_in, hwm_in, live_in;
   logic                  stack_we, map_we, map_wbit;
   logic [MEM_AW-1:0]     stack_wr_addr, map_wr_addr;
   logic [OFFSET_W-1:0]   product;

   // read stage: address the top of stack and the bitmap entry of the head word
   assign pop            = (state_ff == ST_READ) && head.valid;
   assign head_depth     = depth_ff[head.item.pool];
   assign head_depth_dec = head_depth - 1'b1;
   assign stack_rd_addr  = {head.item.pool, head_depth_dec[AW-1:0]};
   assign map_rd_addr    = {head.item.pool, head.item.index[AW-1:0]};

   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign cur_depth = depth_ff[item_ff.pool];
   assign cur_hwm   = hwm_ff[item_ff.pool];
   assign cur_live  = live_ff[item_ff.pool];
   assign cur_cap   = capacity[item_ff.pool];
   assign map_limit = CAP_W'(MAP_DEPTH);

   assign bump_ok  = (CAP_W'(cur_hwm) < cur_cap) && (CAP_W'(cur_hwm) < map_limit);
   assign index_ok = (CAP_W'(item_ff.index) < cur_cap) && (CAP_W'(item_ff.index) < map_limit);
   // entries at or above the high-water mark were never written since reset
   assign map_hit  = (CAP_W'(item_ff.index) < CAP_W'(cur_hwm)) && map_rd_ff;

   always_comb begin
      ok            = 1'b0;
      slot          = '0;
      status        = STATUS_OK;
      depth_in      = cur_depth;
      hwm_in        = cur_hwm;
      live_in       = cur_live;
      stack_we      = 1'b0;
      map_we        = 1'b0;
      map_wbit      = 1'b0;
      stack_wr_addr = {item_ff.pool, cur_depth[AW-1:0]};
      map_wr_addr   = {item_ff.pool, item_ff.index[AW-1:0]};
      case (item_ff.op)
         OP_ALLOC: begin
            if (cur_depth != '0) begin
               ok       = 1'b1;
               slot     = stack_rd_ff;
               depth_in = cur_depth - 1'b1;
            end else if (bump_ok) begin
               ok     = 1'b1;
               slot   = INDEX_W'(cur_hwm);
               hwm_in = cur_hwm + 1'b1;
            end else begin
               status = STATUS_FULL;
            end
            map_we      = ok;
            map_wbit    = 1'b1;
            map_wr_addr = {item_ff.pool, slot[AW-1:0]};
            live_in     = ok ? cur_live + 1'b1 : cur_live;
         end
         OP_FREE: begin
            slot = item_ff.index;
            if (!index_ok) begin
               status = STATUS_OUT_OF_RANGE;
            end else if (!map_hit) begin
               status = STATUS_NOT_ALLOC;
            end else begin
               ok       = 1'b1;
               map_we   = 1'b1;
               stack_we = 1'b1;
               depth_in = cur_depth + 1'b1;
               live_in  = cur_live - 1'b1;
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   assign product = OFFSET_W'(slot) * OFFSET_W'(stride[item_ff.pool]);

   always_comb begin
      rsp_in.pool_id         = item_ff.pool;
      rsp_in.slot_index      = slot;
      rsp_in.byte_offset     = ok ? product : '0;
      rsp_in.shader_visible  = (item_ff.pool == POOL_RESOURCE) || (item_ff.pool == POOL_SAMPLER);
      rsp_in.status          = status;
      rsp_in.allocated_count = CAP_W'(live_in);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_READ: if (pop) state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_READ;
         default: state_in = ST_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READ;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < POOL_COUNT; p++) begin
            depth_ff[p] <= '0;
            hwm_ff[p]   <= '0;
            live_ff[p]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            rsp_valid_ff           <= 1'b1;
            depth_ff[item_ff.pool] <= depth_in;
            hwm_ff[item_ff.pool]   <= hwm_in;
            live_ff[item_ff.pool]  <= live_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head.item;
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && stack_we) begin
         stack_mem[stack_wr_addr] <= item_ff.index;
      end
      if (pop) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && map_we) begin
         map_mem[map_wr_addr] <= map_wbit;
      end
      if (pop) begin
         map_rd_ff <= map_mem[map_rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// ===== rtl/descriptor_index_allocator.sv =====
// top level of the descriptor index allocator: registers, front end, engine
//
//  channel   direction  handshake              payload
//  req       in         req_tvalid/req_tready  operation, view_type, free_index
//  rsp       out        rsp_tvalid/rsp_tready  pool_id .. allocated_count
//  csr       in         csr_wr_en              csr_addr, csr_wdata
//
// the engine takes one word at a time: it reads the free stack and bitmap, then updates
// the pool in the next cycle; an accepted word passes the queue, the read and update
// states and the result register before rsp_tvalid. no clearing pass after reset:
// bitmap entries at or above a pool's high-water mark read as free. a stalled rsp holds
// the engine in its update cycle; req stays ready until the 2-word queue fills
module descriptor_index_allocator
   import dia_pkg::*;
#(
   parameter int POOL_DEPTH = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // operation, view_type, free_index, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pool_id, slot_index, byte_offset,
                                             // shader_visible, status, allocated_count, pad
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CAP_W-1:0]      csr_wdata
);

   logic [CAP_W-1:0]    capacity_ff [POOL_COUNT];
   logic [STRIDE_W-1:0] stride_ff   [POOL_COUNT];
   queue_head_type      queue_head;
   logic                back_pop;
   result_type          rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POOL_COUNT; p++) begin
            capacity_ff[p] <= CAP_RESET[p];
            stride_ff[p]   <= STRIDE_RESET;
         end
      end else if (csr_wr_en) begin
         if (csr_addr < CSR_RTV_STRIDE) begin
            capacity_ff[csr_addr[POOL_W-1:0]] <= csr_wdata;
         end else begin
            stride_ff[csr_addr[POOL_W-1:0]] <= csr_wdata[STRIDE_W-1:0];
         end
      end
   end

   dia_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (queue_head),
      .pop        (back_pop)
   );

   dia_back #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (queue_head),
      .pop        (back_pop),
      .capacity   (capacity_ff),
      .stride     (stride_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {(RSP_DATA_W - RESULT_W)'(0), rsp_result};

`ifndef ASSERT_OFF
   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> queue_head.valid)
      else $error("engine took a word from an empty queue");

   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> queue_head.valid)
      else $error("accepted word missing from queue");

   a_visible_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_result.shader_visible == rsp_result.pool_id[1])
      else $error("shader visible flag does not match pool");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result.status == STATUS_FULL |->
         rsp_result.slot_index == '0 && rsp_result.byte_offset == '0)
      else $error("pool full result carries an index");
`endif

endmodule
